### sv/rgbb_pkg.sv
// ----------------------------------------------------------------------------
// rgbb_pkg
// Shared types and constants of the 3x3 RGB box blur: payload structs,
// register index codes, reset dimensions and the divide-by-nine helper.
// ----------------------------------------------------------------------------
package rgbb_pkg;

  localparam int PIX_W        = 8;
  localparam int ROW_W        = 12;
  localparam int COL_W        = 10;
  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 13;
  localparam int CFG_W        = 13;
  localparam int WIDTH_RST    = 640;
  localparam int HEIGHT_RST   = 480;

  // sum of nine 8-bit taps, and floor(s/9) as (s * 7282) >> 16, exact below 2296
  localparam int SUM_W        = 12;
  localparam int DIV9_MUL     = 7282;
  localparam int DIV9_SHIFT   = 16;
  localparam int DIV9_PROD_W  = SUM_W + 13;

  localparam int FIFO_DEPTH   = 4;
  localparam int FIFO_AW      = 2;

  typedef enum logic [0:0] {
    CFG_WIDTH  = 1'b0,
    CFG_HEIGHT = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [PIX_W-1:0] red_in;
    logic [PIX_W-1:0] green_in;
    logic [PIX_W-1:0] blue_in;
  } pix_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] red_out;
    logic [PIX_W-1:0] green_out;
    logic [PIX_W-1:0] blue_out;
    logic [ROW_W-1:0] pixel_row;
    logic [COL_W-1:0] pixel_column;
    logic             last_of_run;
  } result_t;

  function automatic logic [PIX_W-1:0] div9(input logic [SUM_W-1:0] s);
    logic [DIV9_PROD_W-1:0] p;
    p = DIV9_PROD_W'(s) * DIV9_PROD_W'(DIV9_MUL);
    return p[DIV9_SHIFT +: PIX_W];
  endfunction

endpackage

### sv/rgbb_stream_if.sv
// ----------------------------------------------------------------------------
// rgbb_stream_if
// Valid/ready stream channel; an item moves when valid and ready are high.
// ----------------------------------------------------------------------------
interface rgbb_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### sv/rgb_box_blur_3x3.sv
// ----------------------------------------------------------------------------
// rgb_box_blur_3x3
// Streaming 3x3 box filter on RGB pixels with border pass-through.
// ----------------------------------------------------------------------------
// Pixels enter in raster order. The line RAM is read when a pixel is accepted;
// in the next cycle the window, the two line pixels and the new pixel are summed
// and divided by nine, and when the stage moves on up to two results (blurred
// interior pixel first, then the border pixel) go into a four-entry result
// queue. The stage holds its pixel while the queue has three or more results,
// and the queue drains one result per clock while the sink is ready: with the
// sink always ready a pixel is taken every clock, except in the last row of a
// frame, where every pixel from the third column on yields two results and the
// stage waits on the queue. Writing a dimension restarts the frame at row 0,
// column 0; write only while the block is idle.
module rgb_box_blur_3x3 #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  rgbb_stream_if.sink                       pix_i,
  rgbb_stream_if.source                     res_o,
  input  logic                              cfg_we_i,
  input  rgbb_pkg::cfg_idx_e                cfg_idx_i,
  input  logic [rgbb_pkg::CFG_W-1:0]        cfg_wdata_i
);
  import rgbb_pkg::*;

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int WCMP  = (WIDTH_REG_W > $clog2(MAX_WIDTH + 1)) ?
                         WIDTH_REG_W : $clog2(MAX_WIDTH + 1);
  localparam int HCMP  = (HEIGHT_REG_W > $clog2(MAX_HEIGHT + 1)) ?
                         HEIGHT_REG_W : $clog2(MAX_HEIGHT + 1);
  localparam int RST_W = (WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RST;
  localparam int RST_H = (HEIGHT_RST > MAX_HEIGHT) ? MAX_HEIGHT : HEIGHT_RST;
  localparam int CNT_W = FIFO_AW + 1;
  localparam int PXW   = 3 * PIX_W;

  // dimensions held as last column / last row index
  logic [CW-1:0] wlast_q, wlast_d;
  logic [RW-1:0] hlast_q, hlast_d;
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;

  logic          accept;
  logic          s1_valid_q;
  pix_in_t       s1_pix_q;
  logic [CW-1:0] s1_col_q;
  logic [RW-1:0] s1_row_q;
  logic          s1_fire;

  logic [2*PXW-1:0] ram_rdata;
  rgb_t             top_px, mid_px, bot_px;
  rgb_t             wc_q [6];

  logic             interior, border;
  logic [SUM_W-1:0] sum_r, sum_g, sum_b;
  logic [RW-1:0]    row_up;
  logic [CW-1:0]    col_left;
  result_t          blur_res, bord_res;

  result_t          fifo_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wp_q, rp_q;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [1:0]         push_n;
  logic               pop;

  // ---- configuration, clamped to the supported range ----
  always_comb begin
    logic [WCMP-1:0] wv;
    logic [HCMP-1:0] hv;
    wv = WCMP'(cfg_wdata_i[WIDTH_REG_W-1:0]);
    hv = HCMP'(cfg_wdata_i[HEIGHT_REG_W-1:0]);
    if (wv == '0) begin
      wv = WCMP'(1);
    end
    if (wv > WCMP'(MAX_WIDTH)) begin
      wv = WCMP'(MAX_WIDTH);
    end
    if (hv == '0) begin
      hv = HCMP'(1);
    end
    if (hv > HCMP'(MAX_HEIGHT)) begin
      hv = HCMP'(MAX_HEIGHT);
    end
    wlast_d = wlast_q;
    hlast_d = hlast_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_WIDTH:  wlast_d = CW'(wv - WCMP'(1));
        CFG_HEIGHT: hlast_d = RW'(hv - HCMP'(1));
        default:    ;
      endcase
    end
  end

  // ---- raster position of the next pixel ----
  assign pix_i.ready = !s1_valid_q || s1_fire;
  assign accept      = pix_i.valid && pix_i.ready;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cfg_we_i) begin
      col_d = '0;
      row_d = '0;
    end else if (accept) begin
      if (col_q == wlast_q) begin
        col_d = '0;
        row_d = (row_q == hlast_q) ? '0 : row_q + RW'(1);
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlast_q    <= CW'(RST_W - 1);
      hlast_q    <= RW'(RST_H - 1);
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      wlast_q    <= wlast_d;
      hlast_q    <= hlast_d;
      col_q      <= col_d;
      row_q      <= row_d;
      s1_valid_q <= accept || (s1_valid_q && !s1_fire);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pix_q <= pix_i.payload;
      s1_col_q <= col_q;
      s1_row_q <= row_q;
    end
  end

  // ---- line store: entry holds {two rows up, one row up} of a column ----
  rgbb_ram #(
    .WIDTH (2 * PXW),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (s1_fire),
    .waddr_i (s1_col_q),
    .wdata_i ({mid_px, bot_px}),
    .re_i    (accept),
    .raddr_i (col_q),
    .rdata_o (ram_rdata)
  );

  assign top_px = rgb_t'(ram_rdata[2*PXW-1:PXW]);
  assign mid_px = rgb_t'(ram_rdata[PXW-1:0]);
  assign bot_px = rgb_t'({s1_pix_q.red_in, s1_pix_q.green_in, s1_pix_q.blue_in});

  // ---- window sums and results ----
  always_comb begin
    rgb_t nb [9];
    for (int i = 0; i < 6; i++) begin
      nb[i] = wc_q[i];
    end
    nb[6] = top_px;
    nb[7] = mid_px;
    nb[8] = bot_px;
    sum_r = '0;
    sum_g = '0;
    sum_b = '0;
    for (int i = 0; i < 9; i++) begin
      sum_r = sum_r + SUM_W'(nb[i].red);
      sum_g = sum_g + SUM_W'(nb[i].green);
      sum_b = sum_b + SUM_W'(nb[i].blue);
    end
  end

  assign interior = (s1_row_q >= RW'(2)) && (s1_col_q >= CW'(2));
  assign border   = (s1_row_q == '0) || (s1_row_q == hlast_q) ||
                    (s1_col_q == '0) || (s1_col_q == wlast_q);
  assign row_up   = s1_row_q - RW'(1);
  assign col_left = s1_col_q - CW'(1);

  always_comb begin
    blur_res.red_out      = div9(sum_r);
    blur_res.green_out    = div9(sum_g);
    blur_res.blue_out     = div9(sum_b);
    blur_res.pixel_row    = ROW_W'(row_up);
    blur_res.pixel_column = COL_W'(col_left);
    blur_res.last_of_run  = !border;
    bord_res.red_out      = bot_px.red;
    bord_res.green_out    = bot_px.green;
    bord_res.blue_out     = bot_px.blue;
    bord_res.pixel_row    = ROW_W'(s1_row_q);
    bord_res.pixel_column = COL_W'(s1_col_q);
    bord_res.last_of_run  = 1'b1;
  end

  // the stage moves on only when the queue can take two results
  assign s1_fire = s1_valid_q && (cnt_q <= CNT_W'(FIFO_DEPTH - 2));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) begin
        wc_q[i] <= '0;
      end
    end else if (s1_fire) begin
      wc_q[0] <= wc_q[3];
      wc_q[1] <= wc_q[4];
      wc_q[2] <= wc_q[5];
      wc_q[3] <= top_px;
      wc_q[4] <= mid_px;
      wc_q[5] <= bot_px;
    end
  end

  // ---- result queue ----
  assign push_n = s1_fire ? ({1'b0, interior} + {1'b0, border}) : 2'd0;
  assign pop    = res_o.valid && res_o.ready;
  assign cnt_d  = cnt_q + CNT_W'(push_n) - CNT_W'(pop);

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      if (interior) begin
        fifo_q[wp_q] <= blur_res;
      end
      if (border) begin
        fifo_q[wp_q + FIFO_AW'(interior)] <= bord_res;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_q + FIFO_AW'(push_n);
      rp_q  <= rp_q + FIFO_AW'(pop);
      cnt_q <= cnt_d;
    end
  end

  assign res_o.valid   = (cnt_q != '0);
  assign res_o.payload = fifo_q[rp_q];

  // ---- checks ----
  a_fifo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(FIFO_DEPTH))
    else $error("result queue overflow");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (col_q <= wlast_q) && (row_q <= hlast_q))
    else $error("raster position outside the frame");

  a_stage_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> s1_valid_q)
    else $error("accepted pixel lost before the window stage");
endmodule

### sv/rgbb_ram.sv
// ----------------------------------------------------------------------------
// rgbb_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module rgbb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

### tb/sv/tb_rgb_box_blur_3x3.sv
// ----------------------------------------------------------------------------
// tb_rgb_box_blur_3x3
// Self-checking bench for the 3x3 RGB box blur. A behavioral copy of the line
// stores, the window and the frame position predicts every output pixel, and
// outputs are matched in order while both stream sides stall at random outside a steady stretch.
// ----------------------------------------------------------------------------
module tb_rgb_box_blur_3x3;
  timeunit 1ns;
  timeprecision 1ps;

  import rgbb_pkg::*;

  localparam int MAX_W          = 1024;
  localparam int MAX_H          = 4096;
  localparam int TAPS           = 9;
  localparam int CHAN_MAX       = 255;
  localparam int RESULT_LATENCY = 8;
  localparam int STALL_LIMIT    = 2000;
  localparam int RANDOM_ITEMS   = 800;
  localparam int EXTREME_ITEMS  = 64;
  localparam int MAX_REPORTS    = 10;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we;
  cfg_idx_e         cfg_idx;
  logic [CFG_W-1:0] cfg_wdata;
  bit               steady;
  int               n_bad;
  int               quiet_cycles;

  rgbb_stream_if #(.T(pix_in_t)) pix_if ();
  rgbb_stream_if #(.T(result_t)) res_if ();

  rgb_box_blur_3x3 #(
    .MAX_WIDTH  (MAX_W),
    .MAX_HEIGHT (MAX_H)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pix_i       (pix_if),
    .res_o       (res_if),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  // blur model state
  logic [WIDTH_REG_W-1:0]  width_reg;
  logic [HEIGHT_REG_W-1:0] height_reg;
  rgb_t                    above2[MAX_W];
  rgb_t                    above1[MAX_W];
  rgb_t                    win[6];
  int unsigned             col_pos;
  int unsigned             row_pos;
  result_t                 out_pixels_q[$];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned clamp_dim(input int unsigned raw, input int unsigned hi);
    if (raw < 1) return 1;
    if (raw > hi) return hi;
    return raw;
  endfunction

  function automatic logic [PIX_W-1:0] mean_of(input int unsigned s);
    int unsigned q;
    q = s / TAPS;
    if (q > CHAN_MAX) q = CHAN_MAX;
    return PIX_W'(q);
  endfunction

  function automatic string describe(input result_t p);
    return $sformatf("rgb %02h %02h %02h at row %0d col %0d last %0b",
                     p.red_out, p.green_out, p.blue_out, p.pixel_row, p.pixel_column,
                     p.last_of_run);
  endfunction

  function automatic void flag(input string msg);
    n_bad++;
    if (n_bad <= MAX_REPORTS) $display("%0t: %s", $time, msg);
  endfunction

  // one accepted pixel: up to two output pixels, blurred interior one first
  function automatic void blur_step(input pix_in_t px);
    int unsigned w, h, c, r;
    int unsigned sum_r, sum_g, sum_b;
    rgb_t        bot, top, mid;
    rgb_t        nb[9];
    result_t     item;
    bit          inner, on_border;
    w = clamp_dim(width_reg, MAX_W);
    h = clamp_dim(height_reg, MAX_H);
    c = (col_pos >= w) ? 0 : col_pos;
    r = (row_pos >= h) ? 0 : row_pos;
    bot = {px.red_in, px.green_in, px.blue_in};
    top = above2[c];
    mid = above1[c];
    inner = (r >= 2) && (c >= 2);
    on_border = (r == 0) || (r == h - 1) || (c == 0) || (c == w - 1);
    if (inner) begin
      for (int i = 0; i < 6; i++) nb[i] = win[i];
      nb[6] = top;
      nb[7] = mid;
      nb[8] = bot;
      sum_r = 0;
      sum_g = 0;
      sum_b = 0;
      foreach (nb[i]) begin
        sum_r += nb[i].red;
        sum_g += nb[i].green;
        sum_b += nb[i].blue;
      end
      item.red_out      = mean_of(sum_r);
      item.green_out    = mean_of(sum_g);
      item.blue_out     = mean_of(sum_b);
      item.pixel_row    = ROW_W'(r - 1);
      item.pixel_column = COL_W'(c - 1);
      item.last_of_run  = !on_border;
      out_pixels_q = {out_pixels_q, item};
    end
    if (on_border) begin
      item.red_out      = bot.red;
      item.green_out    = bot.green;
      item.blue_out     = bot.blue;
      item.pixel_row    = ROW_W'(r);
      item.pixel_column = COL_W'(c);
      item.last_of_run  = 1'b1;
      out_pixels_q = {out_pixels_q, item};
    end
    above2[c] = mid;
    above1[c] = bot;
    win[0] = win[3];
    win[1] = win[4];
    win[2] = win[5];
    win[3] = top;
    win[4] = mid;
    win[5] = bot;
    if (c + 1 >= w) begin
      col_pos = 0;
      row_pos = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
      row_pos = r;
    end
  endfunction

  function automatic logic [PIX_W-1:0] rand_chan();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return PIX_W'($urandom);
    endcase
  endfunction

  function automatic pix_in_t rand_pixel();
    pix_in_t px;
    px.red_in   = rand_chan();
    px.green_in = rand_chan();
    px.blue_in  = rand_chan();
    return px;
  endfunction

  // output ready, low about 15% of cycles outside the steady stretch
  initial begin
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      res_if.ready <= steady || ($urandom_range(99) >= 15);
    end
  end

  always @(posedge clk_i) begin : check_outputs
    result_t want;
    if (res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
      if (out_pixels_q.size() == 0) begin
        flag({"output with nothing pending: ", describe(res_if.payload)});
      end else begin
        want = out_pixels_q.pop_front();
        if (res_if.payload.red_out !== want.red_out ||
            res_if.payload.green_out !== want.green_out ||
            res_if.payload.blue_out !== want.blue_out ||
            res_if.payload.pixel_row !== want.pixel_row ||
            res_if.payload.pixel_column !== want.pixel_column ||
            res_if.payload.last_of_run !== want.last_of_run) begin
          flag({"mismatch: got ", describe(res_if.payload), ", want ", describe(want)});
        end
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if ((pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic push_pixel(input pix_in_t px);
    while (!steady && $urandom_range(99) < 15) begin
      pix_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    pix_if.valid   <= 1'b1;
    pix_if.payload <= px;
    do @(posedge clk_i); while (pix_if.ready !== 1'b1);
    blur_step(px);
  endtask

  task automatic send_pixels(input int n, input int pause_at);
    for (int i = 0; i < n; i++) begin
      if (i == pause_at) quiesce();
      push_pixel(rand_pixel());
    end
  endtask

  // hold input until every pending pixel is out, then let the pipe drain
  task automatic quiesce();
    pix_if.valid <= 1'b0;
    do @(posedge clk_i); while (out_pixels_q.size() != 0);
    repeat (RESULT_LATENCY) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      CFG_WIDTH:  width_reg = val[WIDTH_REG_W-1:0];
      CFG_HEIGHT: height_reg = val[HEIGHT_REG_W-1:0];
      default: ;
    endcase
    col_pos = 0;
    row_pos = 0;
    @(posedge clk_i);
  endtask

  task automatic set_frame(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
    quiesce();
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_HEIGHT, h);
  endtask

  // frame size out of reset is 640x480, so these land on the top row
  task automatic test_reset_dims();
    repeat (2) push_pixel(rand_pixel());
  endtask

  task automatic test_saturated_mean();
    set_frame(CFG_W'(3), CFG_W'(3));
    repeat (9) push_pixel('1);
  endtask

  // second frame with no register write: position wraps to the top left
  task automatic test_frame_wrap();
    for (int i = 0; i < 9; i++) push_pixel((i % 2 == 0) ? pix_in_t'('0) : rand_pixel());
  endtask

  // zero dimensions act as one: every item is a single-pixel frame
  task automatic test_zero_dims();
    set_frame('0, '0);
    repeat (2) push_pixel(rand_pixel());
  endtask

  task automatic test_restart();
    set_frame(CFG_W'(4), CFG_W'(3));
    send_pixels(5, -1);
    quiesce();
    write_reg(CFG_HEIGHT, CFG_W'(3));
    send_pixels(2, -1);
  endtask

  // widest rows and tallest column, first items only; upper data bits must
  // not reach the width
  task automatic test_extreme_sizes();
    set_frame('1, CFG_W'(3));
    send_pixels(EXTREME_ITEMS, $urandom_range(EXTREME_ITEMS - 1));
    set_frame(CFG_W'(1), '1);
    send_pixels(EXTREME_ITEMS, -1);
  endtask

  task automatic test_random_frames();
    int               sent, total, pause_at;
    logic [CFG_W-1:0] w_raw, h_raw;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      steady = (sent >= 300) && (sent < 600);
      case ($urandom_range(9))
        0:       w_raw = '0;
        1:       w_raw = CFG_W'($urandom_range(MAX_W + 1, 2047));
        2, 3:    w_raw = CFG_W'($urandom_range(17, 64));
        default: w_raw = CFG_W'($urandom_range(1, 16));
      endcase
      case ($urandom_range(9))
        0:       h_raw = '0;
        1:       h_raw = CFG_W'($urandom_range(MAX_H + 1, 8191));
        default: h_raw = CFG_W'($urandom_range(1, 10));
      endcase
      quiesce();
      // a single write restarts the frame too
      case ($urandom_range(3))
        0: write_reg(CFG_WIDTH, w_raw);
        1: write_reg(CFG_HEIGHT, h_raw);
        default: begin
          write_reg(CFG_HEIGHT, h_raw);
          write_reg(CFG_WIDTH, w_raw);
        end
      endcase
      total = clamp_dim(width_reg, MAX_W) * clamp_dim(height_reg, MAX_H) * $urandom_range(1, 3);
      if (total > 240) total = $urandom_range(60, 240);
      else if ($urandom_range(4) == 0) total = $urandom_range(1, total);
      pause_at = ($urandom_range(2) == 0) ? $urandom_range(total - 1) : -1;
      send_pixels(total, pause_at);
      sent += total;
    end
    steady = 1'b0;
  endtask

  initial begin
    rst_ni         <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_idx        <= CFG_WIDTH;
    cfg_wdata      <= '0;
    pix_if.valid   <= 1'b0;
    pix_if.payload <= '0;
    width_reg  = WIDTH_REG_W'(WIDTH_RST);
    height_reg = HEIGHT_REG_W'(HEIGHT_RST);
    col_pos    = 0;
    row_pos    = 0;
    foreach (win[i]) win[i] = '0;
    foreach (above1[i]) begin
      above1[i] = '0;
      above2[i] = '0;
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_dims();
    test_saturated_mean();
    test_frame_wrap();
    test_zero_dims();
    test_restart();
    test_extreme_sizes();
    test_random_frames();

    quiesce();
    if (n_bad == 0 && out_pixels_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
